### rtl/core/session_table_lru_ttl_assert.svh
// Assertion macros used by the session table datapath.
// Depends on nothing; included by stl_dpath to check its own logic.
`ifndef SESSION_TABLE_LRU_TTL_ASSERT_SVH
`define SESSION_TABLE_LRU_TTL_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define STL_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define STL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

### rtl/core/stl_pkg.sv
// Package of the session table: types, codes and constants.
// Used by the controller, the datapath and the top level.
package stl_pkg;
	localparam int MaxEntries = 16;
	localparam logic [5:0] SweepPeriod = 6'd60;
	localparam logic [31:0] ReservedLimit = 32'd60;
	localparam logic [31:0] DefaultTtlReset = 32'd3600;

	typedef enum logic [2:0] {
		MODE_CREATE_KEYED = 3'd0,
		MODE_CREATE_RES = 3'd1,
		MODE_INSTALL = 3'd2,
		MODE_LOOKUP = 3'd3,
		MODE_REMOVE = 3'd4,
		MODE_TICK = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_NO_KEY = 2'd2,
		ST_EXPIRED = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_DEFAULT_TTL = 1'd0,
		REG_REAP_ENABLE = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_SWEEP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start_scan;
		logic scan_step;
		logic act;
		logic sweep_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic need_sweep;
		logic sweep_done;
	} ctrl_sts_t;
endpackage

### rtl/core/session_table_lru_ttl.sv
// Session table with LRU replacement and TTL expiry.
// Each request scans every entry, then acts; a tick due for a sweep also sweeps every entry.
// A new request is taken only after the previous result is loaded into the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low) empties the table, clears time and sets the next id to one.
// Depends on stl_pkg, stl_ctrl and stl_dpath.
module session_table_lru_ttl #(
	parameter int MAX_ENTRIES = stl_pkg::MaxEntries
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// mode[2:0], session_id[66:3], key_part0..3[322:67], ttl_req[354:323], pad
	input  logic [359:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], result_id[65:2], key_out0..3[321:66], live_count[326:322],
	// evicted[327]
	output logic [327:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	stl_pkg::ctrl_cmd_t cmd;
	stl_pkg::ctrl_sts_t sts;
	logic busy, in_fire, out_free, mvalid_q;
	logic [1:0] status;
	logic [63:0] result_id;
	logic [255:0] key_out;
	logic [4:0] live_count;
	logic evicted;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !mvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	stl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	stl_dpath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.mode(s_tdata[2:0]), .session_id(s_tdata[66:3]), .key_in(s_tdata[322:67]),
		.ttl_req(s_tdata[354:323]),
		.status(status), .result_id(result_id), .key_out(key_out),
		.live_count(live_count), .evicted(evicted)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mvalid_q <= 1'b0;
		else if (cmd.load_out) mvalid_q <= 1'b1;
		else if (m_tready) mvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) m_tdata <= {evicted, live_count, key_out, result_id, status};
	end

	assign m_tvalid = mvalid_q;
endmodule

### rtl/core/stl_ctrl.sv
// Controller state machine of the session table.
// Depends on stl_pkg; drives the datapath through a command struct.
module stl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  logic                  out_free,
	input  stl_pkg::ctrl_sts_t    sts,
	output stl_pkg::ctrl_cmd_t    cmd,
	output logic                  busy
);
	stl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= stl_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stl_pkg::S_IDLE: if (in_fire) state_d = stl_pkg::S_SCAN;
			stl_pkg::S_SCAN: if (sts.scan_done) state_d = stl_pkg::S_ACT;
			stl_pkg::S_ACT: state_d = sts.need_sweep ? stl_pkg::S_SWEEP : stl_pkg::S_OUT;
			stl_pkg::S_SWEEP: if (sts.sweep_done) state_d = stl_pkg::S_OUT;
			stl_pkg::S_OUT: if (out_free) state_d = stl_pkg::S_IDLE;
			default: state_d = stl_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.start_scan = in_fire;
		cmd.scan_step = (state_q == stl_pkg::S_SCAN);
		cmd.act = (state_q == stl_pkg::S_ACT);
		cmd.sweep_step = (state_q == stl_pkg::S_SWEEP);
		cmd.load_out = (state_q == stl_pkg::S_OUT) && out_free;
		busy = (state_q != stl_pkg::S_IDLE);
	end
endmodule

### rtl/core/stl_dpath.sv
// Datapath of the session table: entry storage, scan, LRU ranks and timers.
// Depends on stl_pkg; sequenced by stl_ctrl.
`include "session_table_lru_ttl_assert.svh"
module stl_dpath #(
	parameter int MAX_ENTRIES = stl_pkg::MaxEntries
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stl_pkg::ctrl_cmd_t cmd,
	output stl_pkg::ctrl_sts_t sts,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	input  logic [2:0]         mode,
	input  logic [63:0]        session_id,
	input  logic [255:0]       key_in,
	input  logic [31:0]        ttl_req,
	output logic [1:0]         status,
	output logic [63:0]        result_id,
	output logic [255:0]       key_out,
	output logic [4:0]         live_count,
	output logic               evicted
);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [IW:0] LastIdx = (IW + 1)'(MAX_ENTRIES - 1);

	logic [MAX_ENTRIES-1:0] valid_q, keyed_q;
	logic [63:0]  ident_q [MAX_ENTRIES];
	logic [255:0] key_q [MAX_ENTRIES];
	logic [31:0]  born_q [MAX_ENTRIES];
	logic [31:0]  life_q [MAX_ENTRIES];
	logic [IW-1:0] rank_q [MAX_ENTRIES];
	logic [31:0] now_q, dttl_q;
	logic reap_q;
	logic [63:0] next_id_q;
	logic [5:0] sweep_cnt_q;
	logic [CW-1:0] count_q;

	logic [2:0] mode_q;
	logic [63:0] id_q;
	logic [255:0] kin_q;
	logic [31:0] ttl_q;
	logic [IW:0] ptr_q;
	logic hit_q, free_q, vic_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, vic_idx_q;
	logic [IW-1:0] vic_rank_q;
	logic [1:0] status_q;
	logic [63:0] rid_q;
	logic [255:0] kout_q;
	logic ev_q;

	logic [IW-1:0] p;
	assign p = ptr_q[IW-1:0];

	function automatic logic expired(input logic [31:0] now, input logic [31:0] born,
		input logic [31:0] life, input logic keyed);
		logic [31:0] age;
		age = now - born;
		return keyed ? (age > life) : (age > stl_pkg::ReservedLimit);
	endfunction

	// Erase of an entry with rank r: ranks above it move down.
	// Promote of an entry with rank r: ranks below it move up.
	logic do_erase, do_promote, do_insert;
	logic [IW-1:0] tgt, tgt_rank;
	logic [1:0] act_status;
	logic [63:0] act_rid;
	logic [255:0] act_key;
	logic act_ev;
	logic [IW-1:0] ins_idx;
	logic ins_ok;

	always_comb begin
		do_erase = 1'b0;
		do_promote = 1'b0;
		do_insert = 1'b0;
		tgt = hit_idx_q;
		act_status = stl_pkg::ST_OK;
		act_rid = id_q;
		act_key = '0;
		act_ev = 1'b0;
		ins_idx = free_idx_q;
		ins_ok = free_q;
		if (count_q == CW'(MAX_ENTRIES) && vic_q) begin
			ins_idx = vic_idx_q;
			ins_ok = 1'b1;
		end
		unique case (mode_q)
			stl_pkg::MODE_CREATE_KEYED, stl_pkg::MODE_CREATE_RES: begin
				act_rid = next_id_q;
				do_insert = ins_ok;
				if (count_q == CW'(MAX_ENTRIES) && vic_q) begin
					act_ev = 1'b1;
					do_erase = 1'b1;
					tgt = vic_idx_q;
				end
			end
			stl_pkg::MODE_INSTALL: begin
				if (!hit_q) act_status = stl_pkg::ST_NOT_FOUND;
			end
			stl_pkg::MODE_LOOKUP: begin
				if (!hit_q) act_status = stl_pkg::ST_NOT_FOUND;
				else if (!keyed_q[hit_idx_q]) act_status = stl_pkg::ST_NO_KEY;
				else if (expired(now_q, born_q[hit_idx_q], life_q[hit_idx_q], 1'b1)) begin
					act_status = stl_pkg::ST_EXPIRED;
					do_erase = 1'b1;
				end else begin
					do_promote = 1'b1;
					act_key = key_q[hit_idx_q];
				end
			end
			stl_pkg::MODE_REMOVE: begin
				if (!hit_q) act_status = stl_pkg::ST_NOT_FOUND;
				else do_erase = 1'b1;
			end
			default: ;
		endcase
		tgt_rank = rank_q[tgt];
	end

	logic sw_kill;
	assign sw_kill = valid_q[p] && expired(now_q, born_q[p], life_q[p], keyed_q[p]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			keyed_q <= '0;
			now_q <= '0;
			dttl_q <= stl_pkg::DefaultTtlReset;
			reap_q <= 1'b0;
			next_id_q <= 64'd1;
			sweep_cnt_q <= '0;
			count_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == stl_pkg::REG_DEFAULT_TTL) dttl_q <= cfg_data;
				else reap_q <= cfg_data[0];
			end
			if (cmd.start_scan) begin
				ptr_q <= '0;
			end else if (cmd.scan_step) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.act) begin
				ptr_q <= '0;
				if (mode_q == stl_pkg::MODE_TICK) begin
					now_q <= now_q + 32'd1;
					if (!reap_q) sweep_cnt_q <= '0;
					else if (sweep_cnt_q + 6'd1 >= stl_pkg::SweepPeriod) sweep_cnt_q <= '0;
					else sweep_cnt_q <= sweep_cnt_q + 6'd1;
				end
				if (mode_q == stl_pkg::MODE_CREATE_KEYED ||
					mode_q == stl_pkg::MODE_CREATE_RES)
					next_id_q <= next_id_q + 64'd1;
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if ((do_insert && IW'(i) == ins_idx) || (do_promote && IW'(i) == tgt))
						rank_q[i] <= '0;
					else if (valid_q[i]) begin
						if (do_erase && rank_q[i] > tgt_rank) begin
							if (!do_insert) rank_q[i] <= rank_q[i] - 1'b1;
						end else if (do_promote && rank_q[i] < tgt_rank)
							rank_q[i] <= rank_q[i] + 1'b1;
						else if (do_insert)
							rank_q[i] <= rank_q[i] + 1'b1;
					end
					if (do_insert && IW'(i) == ins_idx) begin
						valid_q[i] <= 1'b1;
						keyed_q[i] <= (mode_q == stl_pkg::MODE_CREATE_KEYED);
					end else if (do_erase && IW'(i) == tgt) begin
						valid_q[i] <= 1'b0;
						keyed_q[i] <= 1'b0;
					end else if (mode_q == stl_pkg::MODE_INSTALL && hit_q &&
						IW'(i) == hit_idx_q)
						keyed_q[i] <= 1'b1;
				end
				if (do_erase && !do_insert) count_q <= count_q - 1'b1;
				else if (do_insert && !do_erase) count_q <= count_q + 1'b1;
			end
			if (cmd.sweep_step) begin
				ptr_q <= ptr_q + 1'b1;
				if (sw_kill) begin
					valid_q[p] <= 1'b0;
					keyed_q[p] <= 1'b0;
					count_q <= count_q - 1'b1;
					for (int i = 0; i < MAX_ENTRIES; i++)
						if (valid_q[i] && rank_q[i] > rank_q[p]) rank_q[i] <= rank_q[i] - 1'b1;
				end
			end
		end
	end

	// Payload storage and per-item scan results.
	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			mode_q <= mode;
			id_q <= session_id;
			kin_q <= key_in;
			ttl_q <= ttl_req;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			vic_q <= 1'b0;
		end
		if (cmd.scan_step) begin
			if (valid_q[p] && ident_q[p] == id_q && !hit_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= p;
			end
			if (!valid_q[p] && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= p;
			end
			if (valid_q[p] && (!vic_q || rank_q[p] > vic_rank_q)) begin
				vic_q <= 1'b1;
				vic_idx_q <= p;
				vic_rank_q <= rank_q[p];
			end
		end
		if (cmd.act) begin
			status_q <= act_status;
			rid_q <= act_rid;
			kout_q <= act_key;
			ev_q <= act_ev;
			if (mode_q == stl_pkg::MODE_INSTALL && hit_q) begin
				key_q[hit_idx_q] <= kin_q;
				born_q[hit_idx_q] <= now_q;
				if (ttl_q != '0) life_q[hit_idx_q] <= ttl_q;
			end
			if (do_insert) begin
				ident_q[ins_idx] <= next_id_q;
				born_q[ins_idx] <= now_q;
				if (mode_q == stl_pkg::MODE_CREATE_KEYED) begin
					key_q[ins_idx] <= kin_q;
					life_q[ins_idx] <= (ttl_q != '0) ? ttl_q : dttl_q;
				end else begin
					key_q[ins_idx] <= '0;
					life_q[ins_idx] <= dttl_q;
				end
			end
		end
	end

	assign sts.scan_done = cmd.scan_step && (ptr_q == LastIdx);
	assign sts.need_sweep = (mode_q == stl_pkg::MODE_TICK) && reap_q &&
		(sweep_cnt_q + 6'd1 >= stl_pkg::SweepPeriod);
	assign sts.sweep_done = cmd.sweep_step && (ptr_q == LastIdx);

	assign status = status_q;
	assign result_id = rid_q;
	assign key_out = kout_q;
	assign live_count = 5'(count_q);
	assign evicted = ev_q;

	`STL_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(MAX_ENTRIES))
	`STL_ASSERT_IMPL(a_count_match, clk, arst_n, 1'b1, CW'($countones(valid_q)) == count_q)
	`STL_ASSERT_IMPL(a_keyed_valid, clk, arst_n, 1'b1, (keyed_q & ~valid_q) == '0)
	`STL_ASSERT_NEXT(a_tick_time, clk, arst_n, cmd.act && mode_q == stl_pkg::MODE_TICK,
		now_q == $past(now_q) + 32'd1)
endmodule

### tb/tb_session_table_lru_ttl.sv
// Self-checking testbench for session_table_lru_ttl: directed table, then random sessions.
// Results are checked against fixed rows or a table predictor; needs stl_pkg and the DUT.
`timescale 1ns / 1ps
module tb_session_table_lru_ttl;
	typedef struct {
		logic [2:0] mode;
		logic [63:0] sid;
		logic [3:0][63:0] key;
		logic [31:0] ttl;
	} req_t;

	typedef struct {
		logic [1:0] status;
		logic [63:0] rid;
		logic [3:0][63:0] key;
		logic [4:0] live;
		logic evicted;
	} rsp_t;

	typedef struct {
		req_t r;
		bit fixed;
		rsp_t e;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [359:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [327:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;

	// Predicted table contents.
	bit tbl_valid [stl_pkg::MaxEntries];
	bit tbl_keyed [stl_pkg::MaxEntries];
	bit [63:0] tbl_id [stl_pkg::MaxEntries];
	bit [3:0][63:0] tbl_key [stl_pkg::MaxEntries];
	bit [31:0] tbl_born [stl_pkg::MaxEntries];
	bit [31:0] tbl_life [stl_pkg::MaxEntries];
	int unsigned tbl_rank [stl_pkg::MaxEntries];
	bit [31:0] now_s;
	bit [63:0] next_id;
	int unsigned sweep_cnt;
	bit [31:0] ttl_default;
	bit reap_on;

	rsp_t results_due [$];
	dir_row_t directed [$];
	int errors;
	int idle_cycles;
	bit no_stall;
	bit hold_req;
	bit tick_heavy;

	session_table_lru_ttl i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int live_entries();
		int n;
		n = 0;
		for (int i = 0; i < stl_pkg::MaxEntries; i++) if (tbl_valid[i]) n++;
		return n;
	endfunction

	function automatic int slot_of(bit [63:0] id);
		for (int i = 0; i < stl_pkg::MaxEntries; i++)
			if (tbl_valid[i] && tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic void drop_slot(int s);
		int unsigned r;
		r = tbl_rank[s];
		tbl_valid[s] = 0;
		tbl_keyed[s] = 0;
		for (int i = 0; i < stl_pkg::MaxEntries; i++)
			if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
	endfunction

	function automatic void promote_slot(int s);
		int unsigned r;
		r = tbl_rank[s];
		for (int i = 0; i < stl_pkg::MaxEntries; i++)
			if (tbl_valid[i] && i != s && tbl_rank[i] < r) tbl_rank[i]++;
		tbl_rank[s] = 0;
	endfunction

	function automatic bit is_stale(int s);
		bit [31:0] age;
		age = now_s - tbl_born[s];
		return age > (tbl_keyed[s] ? tbl_life[s] : stl_pkg::ReservedLimit);
	endfunction

	function automatic rsp_t table_outcome(req_t r);
		rsp_t e;
		int s;
		int victim;
		int unsigned worst;
		e.status = stl_pkg::ST_OK;
		e.rid = r.sid;
		e.key = '0;
		e.evicted = 0;
		case (r.mode)
			stl_pkg::MODE_CREATE_KEYED, stl_pkg::MODE_CREATE_RES: begin
				if (live_entries() >= stl_pkg::MaxEntries) begin
					victim = -1;
					worst = 0;
					for (int i = 0; i < stl_pkg::MaxEntries; i++)
						if (tbl_valid[i] && (victim < 0 || tbl_rank[i] > worst)) begin
							victim = i;
							worst = tbl_rank[i];
						end
					drop_slot(victim);
					e.evicted = 1;
				end
				s = -1;
				for (int i = 0; i < stl_pkg::MaxEntries && s < 0; i++)
					if (!tbl_valid[i]) s = i;
				e.rid = next_id;
				next_id++;
				for (int i = 0; i < stl_pkg::MaxEntries; i++) if (tbl_valid[i]) tbl_rank[i]++;
				tbl_valid[s] = 1;
				tbl_keyed[s] = (r.mode == stl_pkg::MODE_CREATE_KEYED);
				tbl_id[s] = e.rid;
				if (r.mode == stl_pkg::MODE_CREATE_KEYED) begin
					tbl_key[s] = r.key;
					tbl_life[s] = (r.ttl != 0) ? r.ttl : ttl_default;
				end else begin
					tbl_key[s] = '0;
					tbl_life[s] = ttl_default;
				end
				tbl_born[s] = now_s;
				tbl_rank[s] = 0;
			end
			stl_pkg::MODE_INSTALL: begin
				s = slot_of(r.sid);
				if (s < 0) e.status = stl_pkg::ST_NOT_FOUND;
				else begin
					tbl_key[s] = r.key;
					tbl_keyed[s] = 1;
					if (r.ttl != 0) tbl_life[s] = r.ttl;
					tbl_born[s] = now_s;
				end
			end
			stl_pkg::MODE_LOOKUP: begin
				s = slot_of(r.sid);
				if (s < 0) e.status = stl_pkg::ST_NOT_FOUND;
				else if (!tbl_keyed[s]) e.status = stl_pkg::ST_NO_KEY;
				else if (is_stale(s)) begin
					drop_slot(s);
					e.status = stl_pkg::ST_EXPIRED;
				end else begin
					promote_slot(s);
					e.key = tbl_key[s];
				end
			end
			stl_pkg::MODE_REMOVE: begin
				s = slot_of(r.sid);
				if (s < 0) e.status = stl_pkg::ST_NOT_FOUND;
				else drop_slot(s);
			end
			stl_pkg::MODE_TICK: begin
				now_s++;
				if (!reap_on) sweep_cnt = 0;
				else begin
					sweep_cnt++;
					if (sweep_cnt >= stl_pkg::SweepPeriod) begin
						sweep_cnt = 0;
						for (int i = 0; i < stl_pkg::MaxEntries; i++)
							if (tbl_valid[i] && is_stale(i)) drop_slot(i);
					end
				end
			end
			default: ;
		endcase
		e.live = 5'(live_entries());
		return e;
	endfunction

	function automatic dir_row_t drow(logic [2:0] m, logic [63:0] id, logic [63:0] k,
			logic [31:0] ttl, bit fx, logic [1:0] st, logic [63:0] rid, logic [63:0] ko,
			logic [4:0] lc);
		dir_row_t d;
		d.r = '{m, id, {4{k}}, ttl};
		d.fixed = fx;
		d.e = '{st, rid, {4{ko}}, lc, 1'b0};
		return d;
	endfunction

	task automatic send_request(req_t r, bit fx, rsp_t fe);
		rsp_t e;
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, r.ttl, r.key, r.sid, r.mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		e = table_outcome(r);
		results_due.push_back(fx ? fe : e);
	endtask

	task automatic gap_after();
		int g;
		g = no_stall ? 0 : $urandom_range(0, 11);
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(stl_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == stl_pkg::REG_DEFAULT_TTL) ttl_default = val;
		else reap_on = val[0];
	endtask

	function automatic req_t random_request();
		req_t r;
		int p;
		p = $urandom_range(0, 99);
		if (tick_heavy) begin
			if (p < 50) r.mode = stl_pkg::MODE_TICK;
			else if (p < 62) r.mode = stl_pkg::MODE_CREATE_KEYED;
			else if (p < 68) r.mode = stl_pkg::MODE_CREATE_RES;
			else if (p < 76) r.mode = stl_pkg::MODE_INSTALL;
			else if (p < 92) r.mode = stl_pkg::MODE_LOOKUP;
			else if (p < 97) r.mode = stl_pkg::MODE_REMOVE;
			else r.mode = 3'($urandom_range(6, 7));
		end else begin
			if (p < 22) r.mode = stl_pkg::MODE_CREATE_KEYED;
			else if (p < 32) r.mode = stl_pkg::MODE_CREATE_RES;
			else if (p < 46) r.mode = stl_pkg::MODE_INSTALL;
			else if (p < 70) r.mode = stl_pkg::MODE_LOOKUP;
			else if (p < 80) r.mode = stl_pkg::MODE_REMOVE;
			else if (p < 97) r.mode = stl_pkg::MODE_TICK;
			else r.mode = 3'($urandom_range(6, 7));
		end
		if ($urandom_range(0, 3) == 0) r.sid = {$urandom, $urandom};
		else r.sid = next_id - 64'($urandom_range(1, 20));
		for (int w = 0; w < 4; w++) r.key[w] = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: r.ttl = 0;
			1: r.ttl = $urandom_range(1, 15);
			2: r.ttl = $urandom_range(16, 200);
			default: r.ttl = $urandom;
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [255:0] e, logic [255:0] a);
		if (e !== a) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
		end
	endtask

	// Result side: random back-pressure plus one long hold-off on request.
	initial begin
		rsp_t e;
		int st;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end
			st = no_stall ? 0 : $urandom_range(0, 11);
			if (st > 0) begin
				m_tready <= 1'b0;
				repeat (st) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, got %h", $time, m_tdata);
			end else begin
				e = results_due.pop_front();
				check_field("status", 256'(e.status), 256'(m_tdata[1:0]));
				check_field("result_id", 256'(e.rid), 256'(m_tdata[65:2]));
				check_field("key_out", e.key, m_tdata[321:66]);
				check_field("live_count", 256'(e.live), 256'(m_tdata[326:322]));
				check_field("evicted", 256'(e.evicted), 256'(m_tdata[327]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 3000) begin
			$display("tb_session_table_lru_ttl: done, errors");
			$finish;
		end
	end

	initial begin
		logic [63:0] ones;
		logic [31:0] ttl_set [5];
		bit reap_set [5];
		rsp_t none;
		ones = '1;
		none = '{2'b0, 64'b0, '0, 5'b0, 1'b0};
		ttl_set = '{32'd5, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd40};
		reap_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
		errors = 0;
		idle_cycles = 0;
		no_stall = 0;
		hold_req = 0;
		tick_heavy = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < stl_pkg::MaxEntries; i++) begin
			tbl_valid[i] = 0;
			tbl_keyed[i] = 0;
		end
		now_s = 0;
		next_id = 1;
		sweep_cnt = 0;
		ttl_default = stl_pkg::DefaultTtlReset;
		reap_on = 0;

		directed.push_back(drow(stl_pkg::MODE_LOOKUP, 0, 0, 0, 1,
			stl_pkg::ST_NOT_FOUND, 0, 0, 0));
		directed.push_back(drow(stl_pkg::MODE_REMOVE, ones, ones, 32'hFFFF_FFFF, 1,
			stl_pkg::ST_NOT_FOUND, ones, 0, 0));
		directed.push_back(drow(stl_pkg::MODE_INSTALL, 5, ones, 7, 1,
			stl_pkg::ST_NOT_FOUND, 5, 0, 0));
		directed.push_back(drow(stl_pkg::MODE_CREATE_KEYED, 77, ones, 0, 1,
			stl_pkg::ST_OK, 1, 0, 1));
		directed.push_back(drow(stl_pkg::MODE_CREATE_RES, 0, 64'h5555_5555_5555_5555, 9,
			1, stl_pkg::ST_OK, 2, 0, 2));
		directed.push_back(drow(stl_pkg::MODE_LOOKUP, 1, 0, 0, 1, stl_pkg::ST_OK, 1, ones, 2));
		directed.push_back(drow(stl_pkg::MODE_LOOKUP, 2, 0, 0, 1, stl_pkg::ST_NO_KEY, 2, 0, 2));
		directed.push_back(drow(stl_pkg::MODE_INSTALL, 2, 0, 2, 1, stl_pkg::ST_OK, 2, 0, 2));
		repeat (3) directed.push_back(drow(stl_pkg::MODE_TICK, 0, 0, 0, 1,
			stl_pkg::ST_OK, 0, 0, 2));
		directed.push_back(drow(stl_pkg::MODE_LOOKUP, 2, 0, 0, 1,
			stl_pkg::ST_EXPIRED, 2, 0, 1));
		directed.push_back(drow(3'd6, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 1, stl_pkg::ST_OK,
			64'hAAAA_AAAA_AAAA_AAAA, 0, 1));
		directed.push_back(drow(3'd7, ones, ones, 32'hFFFF_FFFF, 1, stl_pkg::ST_OK,
			ones, 0, 1));
		directed.push_back(drow(stl_pkg::MODE_CREATE_KEYED, 0, 64'hA5A5_5A5A_0F0F_F0F0,
			32'hFFFF_FFFF, 1, stl_pkg::ST_OK, 3, 0, 2));
		directed.push_back(drow(stl_pkg::MODE_LOOKUP, 3, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(drow(stl_pkg::MODE_REMOVE, 1, 0, 0, 1, stl_pkg::ST_OK, 1, 0, 1));
		directed.push_back(drow(stl_pkg::MODE_LOOKUP, 1, 0, 0, 1,
			stl_pkg::ST_NOT_FOUND, 1, 0, 1));
		directed.push_back(drow(stl_pkg::MODE_INSTALL, 3, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(drow(stl_pkg::MODE_LOOKUP, 3, 0, 0, 0, 0, 0, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_request(directed[i].r, directed[i].fixed, directed[i].e);
			gap_after();
		end
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(stl_pkg::REG_DEFAULT_TTL, ttl_set[ph]);
			write_reg(stl_pkg::REG_REAP_ENABLE, 32'(reap_set[ph]));
			no_stall = (ph == 3);
			tick_heavy = reap_set[ph];
			for (int n = 0; n < 110; n++) begin
				if (ph == 1 && n == 20) hold_req = 1;
				send_request(random_request(), 0, none);
				gap_after();
			end
			drain();
		end

		no_stall = 0;
		drain();
		if (errors == 0) $display("tb_session_table_lru_ttl: done, clean");
		else $display("tb_session_table_lru_ttl: done, errors");
		$finish;
	end
endmodule
